// ----- rtl/rldt_pkg.sv -----
// Shared types and constants for the run-list decode and translate unit.
// No dependencies.
`timescale 1ns / 1ps
package rldt_pkg;

    localparam int DEF_MAX_RUNS = 64;
    localparam int REC_W        = 17;
    localparam int CLU_W        = 22;
    localparam int NUM_W        = 48;
    localparam int WORD_W       = 64;
    localparam int STAT_W       = 3;
    localparam int HELD_W       = 7;

    // item opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_XLATE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_STORED   = 3'd1;
    localparam logic [2:0] ST_END      = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_MAPPED   = 3'd4;
    localparam logic [2:0] ST_UNMAPPED = 3'd5;

    // configuration register indexes
    localparam logic CFG_RECORD  = 1'b0;
    localparam logic CFG_CLUSTER = 1'b1;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_LEN  = 2'd1,
        PH_OFF  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SCAN,
        S_MLO,
        S_MHI,
        S_FIN
    } t_state;

endpackage

// ----- rtl/rldt_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rldt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/run_list_decode_translate_unit.sv -----
// Run-list decoder with a run table held in one RAM, plus record translation.
// Byte, clear and undefined items load the result register at their accepting edge.
// A translate item loads it after a multiply, a 64-step bit-serial divide, one RAM read
// per table entry scanned, two multiply halves and a final sum; with zero cluster size it
// goes straight to the final state and reports unmapped. One item is in work at a
// time. Sync active-low reset: restore 1024/4096 registers and control; table is junk.
`timescale 1ns / 1ps
module run_list_decode_translate_unit #(
    parameter int MAX_RUNS = rldt_pkg::DEF_MAX_RUNS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [7:0]                  i_run_byte,
    input  logic [rldt_pkg::NUM_W-1:0]  i_record_number,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rldt_pkg::STAT_W-1:0] o_status,
    output logic [rldt_pkg::WORD_W-1:0] o_byte_offset,
    output logic [rldt_pkg::HELD_W-1:0] o_runs_held,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [rldt_pkg::CLU_W-1:0]  i_cfg_data
);

    localparam int AW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RCW = $clog2(MAX_RUNS + 1);
    localparam int W   = rldt_pkg::WORD_W;
    localparam int EW  = 3 * W;

    // configuration registers
    logic [rldt_pkg::REC_W-1:0] r_record_bytes;
    logic [rldt_pkg::CLU_W-1:0] r_cluster_bytes;

    // parser state
    rldt_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_len_left, n_len_left;
    logic [3:0]       r_off_left, n_off_left;
    logic [3:0]       r_off_width, n_off_width;
    logic [3:0]       r_pos, n_pos;
    logic [W-1:0]     r_len, n_len;
    logic [W-1:0]     r_off, n_off;
    logic [W-1:0]     r_virt, n_virt;
    logic [W-1:0]     r_logical, n_logical;
    logic [RCW-1:0]   r_count, n_count;

    // translate datapath
    rldt_pkg::t_state r_state, n_state;
    logic [rldt_pkg::NUM_W-1:0] r_rec;
    logic [W-1:0]               r_quo;
    logic [rldt_pkg::CLU_W:0]   r_rem;
    logic [6:0]                 r_step;
    logic [RCW-1:0]             r_ri;
    logic                       r_chk;
    logic [W-1:0]               r_acc;
    logic [W-1:0]               r_p0;
    logic [31:0]                r_p1;

    // output register
    logic                        r_o_valid;
    logic [rldt_pkg::STAT_W-1:0] r_status;
    logic [W-1:0]                r_byte_offset;

    // table RAM: {virtual start, logical start, length}
    logic          w_we;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;
    logic [AW-1:0] w_raddr;

    logic          w_accept;
    logic          w_out_free;
    logic [2:0]    w_byte_st;
    logic          w_fin;
    logic [3:0]    w_w;
    logic [6:0]    w_sidx;
    logic [W-1:0]  w_sext;

    logic [W-1:0]  w_vs, w_ls, w_rl, w_diff;
    logic          w_hit;
    logic [rldt_pkg::CLU_W+1:0] w_trial;
    logic [RCW+rldt_pkg::HELD_W-1:0] w_held_ext;

    rldt_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_RUNS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // The output register frees up when empty or taken this cycle.
    assign w_out_free = !r_o_valid || !i_stall;
    assign o_stall    = (r_state != rldt_pkg::S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_byte_offset = r_byte_offset;
    assign w_held_ext    = {{rldt_pkg::HELD_W{1'b0}}, r_count};
    assign o_runs_held   = w_held_ext[rldt_pkg::HELD_W-1:0];

    // Run-list byte parser: one byte per cycle while o_stall is low, all in flops.
    always_comb begin
        n_phase     = r_phase;
        n_len_left  = r_len_left;
        n_off_left  = r_off_left;
        n_off_width = r_off_width;
        n_pos       = r_pos;
        n_len       = r_len;
        n_off       = r_off;
        n_virt      = r_virt;
        n_logical   = r_logical;
        n_count     = r_count;
        w_byte_st   = rldt_pkg::ST_TAKEN;
        w_fin       = 1'b0;
        w_we        = 1'b0;
        w_w         = 4'd0;
        w_sidx      = 7'd0;
        w_sext      = '0;
        case (r_phase)
            rldt_pkg::PH_LEN: begin
                if (r_pos < 4'd8) begin
                    n_len = r_len | ({56'd0, i_run_byte} << {r_pos, 3'b000});
                end
                n_pos      = r_pos + 4'd1;
                n_len_left = r_len_left - 4'd1;
                if (n_len_left == 4'd0) begin
                    n_pos = 4'd0;
                    if (r_off_left != 4'd0) begin
                        n_phase = rldt_pkg::PH_OFF;
                    end else begin
                        w_fin = 1'b1;
                    end
                end
            end
            rldt_pkg::PH_OFF: begin
                if (r_pos < 4'd8) begin
                    n_off = r_off | ({56'd0, i_run_byte} << {r_pos, 3'b000});
                end
                n_pos      = r_pos + 4'd1;
                n_off_left = r_off_left - 4'd1;
                if (n_off_left == 4'd0) begin
                    w_fin = 1'b1;
                end
            end
            default: begin
                if (i_run_byte == 8'd0) begin
                    // end of list: restart running counters
                    n_virt    = '0;
                    n_logical = '0;
                    n_phase   = rldt_pkg::PH_HEAD;
                    w_byte_st = rldt_pkg::ST_END;
                end else begin
                    n_len_left  = i_run_byte[3:0];
                    n_off_left  = i_run_byte[7:4];
                    n_off_width = i_run_byte[7:4];
                    n_len       = '0;
                    n_off       = '0;
                    n_pos       = 4'd0;
                    n_phase     = (i_run_byte[3:0] != 4'd0) ? rldt_pkg::PH_LEN
                                                            : rldt_pkg::PH_OFF;
                end
            end
        endcase

        if (w_fin) begin
            // sign-extend offsets shorter than eight bytes
            w_w    = (r_off_width > 4'd8) ? 4'd8 : r_off_width;
            w_sext = n_off;
            w_sidx = {w_w[3:0], 3'b000} - 7'd1;
            if (w_w != 4'd0 && w_w < 4'd8 && n_off[w_sidx[5:0]]) begin
                w_sext = n_off | ({W{1'b1}} << {w_w, 3'b000});
            end
            n_logical = r_logical + w_sext;
            if (r_count < RCW'(MAX_RUNS)) begin
                w_we      = w_accept && (i_op == rldt_pkg::OP_BYTE);
                n_count   = r_count + RCW'(1);
                w_byte_st = rldt_pkg::ST_STORED;
            end else begin
                w_byte_st = rldt_pkg::ST_FULL;
            end
            n_virt  = r_virt + n_len;
            n_phase = rldt_pkg::PH_HEAD;
            n_pos   = 4'd0;
        end
    end

    assign w_wdata = {r_virt, n_logical, n_len};

    // Table scan compare on the registered RAM word.
    assign w_vs    = w_rdata[EW-1:2*W];
    assign w_ls    = w_rdata[2*W-1:W];
    assign w_rl    = w_rdata[W-1:0];
    assign w_diff  = r_quo - w_vs;
    assign w_hit   = r_chk && (r_quo >= w_vs) && (w_diff < w_rl);
    assign w_raddr = r_ri[AW-1:0];
    assign w_trial = {r_rem, r_quo[W-1]} - {2'b00, r_cluster_bytes};

    always_comb begin
        n_state = r_state;
        case (r_state)
            rldt_pkg::S_IDLE: begin
                if (w_accept && i_op == rldt_pkg::OP_XLATE) begin
                    n_state = (r_cluster_bytes == '0) ? rldt_pkg::S_FIN : rldt_pkg::S_MUL;
                end
            end
            rldt_pkg::S_MUL:  n_state = rldt_pkg::S_DIV;
            rldt_pkg::S_DIV:  n_state = (r_step == 7'd63) ? rldt_pkg::S_SCAN
                                                          : rldt_pkg::S_DIV;
            rldt_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = rldt_pkg::S_MLO;
                end else if (r_ri >= r_count) begin
                    n_state = rldt_pkg::S_FIN;
                end
            end
            rldt_pkg::S_MLO:  n_state = rldt_pkg::S_MHI;
            rldt_pkg::S_MHI:  n_state = rldt_pkg::S_FIN;
            rldt_pkg::S_FIN:  n_state = w_out_free ? rldt_pkg::S_IDLE : rldt_pkg::S_FIN;
            default:          n_state = rldt_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_bytes  <= rldt_pkg::REC_W'(1024);
            r_cluster_bytes <= rldt_pkg::CLU_W'(4096);
            r_phase         <= rldt_pkg::PH_HEAD;
            r_len_left      <= 4'd0;
            r_off_left      <= 4'd0;
            r_off_width     <= 4'd0;
            r_pos           <= 4'd0;
            r_len           <= '0;
            r_off           <= '0;
            r_virt          <= '0;
            r_logical       <= '0;
            r_count         <= '0;
            r_state         <= rldt_pkg::S_IDLE;
            r_o_valid       <= 1'b0;
            r_chk           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rldt_pkg::CFG_RECORD) begin
                    r_record_bytes <= i_cfg_data[rldt_pkg::REC_W-1:0];
                end else begin
                    r_cluster_bytes <= i_cfg_data;
                end
            end
            r_state <= n_state;
            // set for a byte, clear or undefined item or a finished translate, drop when taken
            if (w_accept && i_op != rldt_pkg::OP_XLATE) begin
                r_o_valid <= 1'b1;
            end else if (r_state == rldt_pkg::S_FIN && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (w_accept) begin
                case (i_op)
                    rldt_pkg::OP_BYTE: begin
                        r_phase     <= n_phase;
                        r_len_left  <= n_len_left;
                        r_off_left  <= n_off_left;
                        r_off_width <= n_off_width;
                        r_pos       <= n_pos;
                        r_len       <= n_len;
                        r_off       <= n_off;
                        r_virt      <= n_virt;
                        r_logical   <= n_logical;
                        r_count     <= n_count;
                    end
                    rldt_pkg::OP_CLEAR: begin
                        r_count <= '0;
                    end
                    rldt_pkg::OP_XLATE: begin
                        r_chk <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == rldt_pkg::S_SCAN) begin
                r_chk <= !w_hit && (r_ri < r_count);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rec         <= i_record_number;
            r_status      <= (i_op == rldt_pkg::OP_BYTE) ? w_byte_st : rldt_pkg::ST_TAKEN;
            r_byte_offset <= '0;
            r_step        <= 7'd0;
            r_ri          <= '0;
            r_rem         <= '0;
        end
        case (r_state)
            rldt_pkg::S_MUL: begin
                r_quo <= W'({16'd0, r_rec} * {47'd0, r_record_bytes});
            end
            rldt_pkg::S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!w_trial[rldt_pkg::CLU_W+1]) begin
                    r_rem <= w_trial[rldt_pkg::CLU_W:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[rldt_pkg::CLU_W-1:0], r_quo[W-1]};
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_step <= r_step + 7'd1;
            end
            rldt_pkg::S_SCAN: begin
                if (w_hit) begin
                    r_acc <= w_ls + w_diff;
                end else if (r_ri < r_count) begin
                    r_ri <= r_ri + RCW'(1);
                end else begin
                    r_status <= rldt_pkg::ST_UNMAPPED;
                end
            end
            rldt_pkg::S_MLO: begin
                r_p0 <= W'(r_acc[31:0] * r_cluster_bytes);
            end
            rldt_pkg::S_MHI: begin
                r_p1     <= 32'(r_acc[W-1:32] * r_cluster_bytes);
                r_status <= rldt_pkg::ST_MAPPED;
            end
            rldt_pkg::S_FIN: begin
                if (r_status == rldt_pkg::ST_MAPPED) begin
                    r_byte_offset <= r_p0 + {r_p1, 32'd0}
                                   + W'(r_rem[rldt_pkg::CLU_W-1:0]);
                end else begin
                    r_status      <= rldt_pkg::ST_UNMAPPED;
                    r_byte_offset <= '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
